// File: rtl/core/nske_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nske_pkg: shared types and constants of the natural sort key encoder
// Byte constants, source select codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package nske_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned LEN_W  = 6;

	localparam logic [CHAR_W-1:0] RUN_MARKER   = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;
	localparam logic [CHAR_W-1:0] RUN_SAT      = 8'hFF;
	localparam logic [CHAR_W-1:0] ZERO_RUN_LEN = 8'h01;
	localparam logic [LEN_W-1:0]  CAP_RESET    = 6'd32;

	// where the next key byte comes from
	typedef enum logic [2:0] {
		SRC_INPUT = 3'd0,
		SRC_MARK  = 3'd1,
		SRC_LEN   = 3'd2,
		SRC_DIGIT = 3'd3,
		SRC_CHAR  = 3'd4
	} src_t;

	typedef struct packed {
		logic accept;      // take the input character
		logic emit;        // load a key byte into the output register
		logic empty;       // load an empty terminating result
		logic last;        // mark the loaded result as last
		src_t src;
		logic close_run;   // digit run flushed
		logic close_name;  // name done, clear per-name state
		logic dig_step;    // advance the digit read index
		logic dig_clear;   // rewind the digit read index
	} cmd_t;

	typedef struct packed {
		logic in_digit;    // current input character is a digit
		logic run_open;
		logic room;        // key has space for one more byte
		logic room_one;    // exactly one byte of space left
		logic dig_last;    // current digit candidate ends the run
		logic out_free;    // output register can take a result
		logic pend;        // accepted character is a non-digit still to emit
		logic end_q;       // accepted character ends the name
		logic any_q;       // a byte was emitted for the current character
	} sts_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic [CHAR_W-1:0] lower_char(input logic [CHAR_W-1:0] c);
		if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
			return c + CASE_OFFSET;
		end
		return c;
	endfunction

endpackage

// File: rtl/core/nske_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nske_ctrl: sequencing state machine
// Accepts characters and steps through the marker, length and digit bytes of
// a digit run, the held character and the empty terminating result.
// ----------------------------------------------------------------------------
module nske_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tlast,
	output logic             s_tready,
	input  nske_pkg::sts_t   sts,
	output nske_pkg::cmd_t   cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MARK  = 6'b000010,
		ST_LEN   = 6'b000100,
		ST_DIG   = 6'b001000,
		ST_CHAR  = 6'b010000,
		ST_EMPTY = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   go;
	logic   emit_now;
	logic   take;

	assign go       = !sts.room || sts.out_free;
	assign emit_now = sts.room && sts.out_free;
	assign s_tready = (state_q == ST_IDLE) && sts.out_free;
	assign take     = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.src = nske_pkg::SRC_INPUT;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					cmd.accept = 1'b1;
					if (sts.in_digit) begin
						if (s_tlast) begin
							state_d = ST_MARK;
						end
					end else if (sts.run_open) begin
						state_d = ST_MARK;
					end else begin
						// plain character goes straight out
						cmd.emit = sts.room;
						cmd.last = s_tlast;
						if (s_tlast) begin
							if (sts.room) begin
								cmd.close_name = 1'b1;
							end else begin
								state_d = ST_EMPTY;
							end
						end
					end
				end
			end
			ST_MARK: begin
				cmd.src  = nske_pkg::SRC_MARK;
				cmd.emit = emit_now;
				cmd.last = sts.end_q && sts.room_one;
				if (go) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				cmd.src  = nske_pkg::SRC_LEN;
				cmd.emit = emit_now;
				cmd.last = sts.end_q && sts.room_one;
				if (go) begin
					state_d = ST_DIG;
				end
			end
			ST_DIG: begin
				cmd.src  = nske_pkg::SRC_DIGIT;
				cmd.emit = emit_now;
				cmd.last = sts.end_q && (sts.room_one || (sts.dig_last && !sts.pend));
				if (go) begin
					if (sts.dig_last) begin
						cmd.close_run = 1'b1;
						cmd.dig_clear = 1'b1;
						if (sts.pend) begin
							state_d = ST_CHAR;
						end else if (sts.any_q || emit_now) begin
							cmd.close_name = 1'b1;
							state_d        = ST_IDLE;
						end else begin
							state_d = ST_EMPTY;
						end
					end else begin
						cmd.dig_step = 1'b1;
					end
				end
			end
			ST_CHAR: begin
				cmd.src  = nske_pkg::SRC_CHAR;
				cmd.emit = emit_now;
				cmd.last = sts.end_q;
				if (go) begin
					if (!sts.end_q) begin
						state_d = ST_IDLE;
					end else if (sts.any_q || emit_now) begin
						cmd.close_name = 1'b1;
						state_d        = ST_IDLE;
					end else begin
						state_d = ST_EMPTY;
					end
				end
			end
			ST_EMPTY: begin
				if (sts.out_free) begin
					cmd.empty      = 1'b1;
					cmd.close_name = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/nske_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nske_dp: key datapath
// Capacity register, digit run buffer, per-name counters and the output
// register that holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module nske_dp #(
	parameter int unsigned MAX_KEY = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [nske_pkg::LEN_W-1:0]    cfg_data,
	input  logic [nske_pkg::CHAR_W-1:0]   char_code,
	input  logic                          name_end,
	input  logic                          out_ready,
	input  nske_pkg::cmd_t                cmd,
	output nske_pkg::sts_t                sts,
	output logic                          out_valid,
	output logic [nske_pkg::CHAR_W-1:0]   key_byte,
	output logic                          byte_valid,
	output logic                          key_last,
	output logic [nske_pkg::LEN_W-1:0]    key_length
);

	localparam int unsigned AW = $clog2(MAX_KEY);
	localparam logic [nske_pkg::CHAR_W-1:0] MAX_KEY_B = nske_pkg::CHAR_W'(MAX_KEY);
	localparam logic [nske_pkg::LEN_W-1:0]  MAX_KEY_L = nske_pkg::LEN_W'(MAX_KEY);

	logic [nske_pkg::CHAR_W-1:0] run_mem [MAX_KEY];
	logic [nske_pkg::CHAR_W-1:0] rd_data_q;
	logic [AW-1:0]               rd_addr;
	logic [AW-1:0]               dig_idx_q;

	logic [nske_pkg::LEN_W-1:0]  cap_q;
	logic [nske_pkg::LEN_W-1:0]  eff_cap;
	logic [nske_pkg::LEN_W-1:0]  emitted_q;
	logic [nske_pkg::CHAR_W-1:0] run_count_q;
	logic                        in_run_q;
	logic [nske_pkg::CHAR_W-1:0] char_q;
	logic                        end_q;
	logic                        pend_q;
	logic                        any_q;
	logic                        out_valid_q;
	logic [nske_pkg::CHAR_W-1:0] key_byte_q;
	logic                        byte_valid_q;
	logic                        key_last_q;
	logic [nske_pkg::LEN_W-1:0]  key_length_q;

	logic                        in_digit;
	logic                        keep_digit;
	logic [nske_pkg::CHAR_W-1:0] stored;
	logic [nske_pkg::CHAR_W-1:0] byte_mux;
	logic [nske_pkg::LEN_W-1:0]  emitted_inc;

	assign in_digit    = nske_pkg::is_digit(char_code);
	assign keep_digit  = !((run_count_q == '0) && (char_code == nske_pkg::CHAR_ZERO));
	assign eff_cap     = (cap_q > MAX_KEY_L) ? MAX_KEY_L : cap_q;
	assign stored      = (run_count_q > MAX_KEY_B) ? MAX_KEY_B : run_count_q;
	assign emitted_inc = emitted_q + nske_pkg::LEN_W'(1);

	assign sts.in_digit = in_digit;
	assign sts.run_open = in_run_q;
	assign sts.room     = emitted_q < eff_cap;
	assign sts.room_one = emitted_inc == eff_cap;
	assign sts.dig_last = (run_count_q == '0) ||
		((nske_pkg::CHAR_W'(dig_idx_q) + nske_pkg::CHAR_W'(1)) == stored);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.pend     = pend_q;
	assign sts.end_q    = end_q;
	assign sts.any_q    = any_q;

	always_comb begin
		case (cmd.src)
			nske_pkg::SRC_INPUT: byte_mux = nske_pkg::lower_char(char_code);
			nske_pkg::SRC_MARK:  byte_mux = nske_pkg::RUN_MARKER;
			nske_pkg::SRC_LEN:   byte_mux = (run_count_q == '0) ? nske_pkg::ZERO_RUN_LEN
			                                                   : run_count_q;
			nske_pkg::SRC_DIGIT: byte_mux = (run_count_q == '0) ? nske_pkg::CHAR_ZERO
			                                                   : rd_data_q;
			nske_pkg::SRC_CHAR:  byte_mux = char_q;
			default:             byte_mux = '0;
		endcase
	end

	// look one digit ahead so the registered read lines up with the index
	always_comb begin
		if (cmd.dig_clear) begin
			rd_addr = '0;
		end else if (cmd.dig_step) begin
			rd_addr = dig_idx_q + AW'(1);
		end else begin
			rd_addr = dig_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && in_digit && keep_digit && (run_count_q < MAX_KEY_B)) begin
			run_mem[run_count_q[AW-1:0]] <= char_code;
		end
		rd_data_q <= run_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= nske_pkg::CAP_RESET;
			emitted_q   <= '0;
			run_count_q <= '0;
			in_run_q    <= 1'b0;
			dig_idx_q   <= '0;
			end_q       <= 1'b0;
			pend_q      <= 1'b0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.accept) begin
				end_q  <= name_end;
				pend_q <= !in_digit;
				if (in_digit) begin
					in_run_q <= 1'b1;
					if (keep_digit && (run_count_q != nske_pkg::RUN_SAT)) begin
						run_count_q <= run_count_q + nske_pkg::CHAR_W'(1);
					end
				end
			end
			if (cmd.emit) begin
				any_q <= 1'b1;
			end else if (cmd.accept) begin
				any_q <= 1'b0;
			end
			if (cmd.close_run || cmd.close_name) begin
				run_count_q <= '0;
				in_run_q    <= 1'b0;
			end
			if (cmd.close_name) begin
				emitted_q <= '0;
			end else if (cmd.emit) begin
				emitted_q <= emitted_inc;
			end
			if (cmd.dig_clear) begin
				dig_idx_q <= '0;
			end else if (cmd.dig_step) begin
				dig_idx_q <= dig_idx_q + AW'(1);
			end
			if (cmd.emit || cmd.empty) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			char_q <= nske_pkg::lower_char(char_code);
		end
		if (cmd.emit) begin
			key_byte_q   <= byte_mux;
			byte_valid_q <= 1'b1;
			key_last_q   <= cmd.last;
			key_length_q <= cmd.last ? emitted_inc : '0;
		end else if (cmd.empty) begin
			key_byte_q   <= '0;
			byte_valid_q <= 1'b0;
			key_last_q   <= 1'b1;
			key_length_q <= emitted_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign key_byte   = key_byte_q;
	assign byte_valid = byte_valid_q;
	assign key_last   = key_last_q;
	assign key_length = key_length_q;

endmodule

// File: rtl/core/natural_sort_key_encoder.sv
`timescale 1ns / 1ps
// A non-digit character outside a run is on the output in the cycle after it is accepted.
// Throughput: one character per cycle for digits and outside-run non-digits, if output is free.
// A run flushes as a marker byte, a length byte and up to MAX_KEY buffered digits, then the
// held character and, where due, an empty terminating result; the flush sequencer sets this.
// Reset clears all control state and sets the key capacity to 32; no clearing pass is needed.
// ----------------------------------------------------------------------------
// natural_sort_key_encoder: natural sort key encoder, top level
// Turns a name, one character per request, into a byte-comparable key.
// ----------------------------------------------------------------------------
module natural_sort_key_encoder #(
	parameter int unsigned MAX_KEY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data,   // key_capacity
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] char_code
	input  logic        s_tlast,    // name_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [7:0] key_byte, [13:8] key_length, [15:14] zero
	output logic        m_tuser,    // byte_valid
	output logic        m_tlast     // key_last
);

	nske_pkg::cmd_t              cmd;
	nske_pkg::sts_t              sts;
	logic [nske_pkg::CHAR_W-1:0] key_byte;
	logic [nske_pkg::LEN_W-1:0]  key_length;

	assign cfg_ready = 1'b1;

	nske_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nske_dp #(
		.MAX_KEY (MAX_KEY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.char_code  (s_tdata),
		.name_end   (s_tlast),
		.out_ready  (m_tready),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.key_byte   (key_byte),
		.byte_valid (m_tuser),
		.key_last   (m_tlast),
		.key_length (key_length)
	);

	assign m_tdata = {2'b00, key_length, key_byte};

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("empty result not marked last");

	a_len_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[13:8] == 6'd0)
		else $error("key length on a result that is not last");

	a_last_byte_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tuser |-> m_tdata[13:8] != 6'd0)
		else $error("last key byte carries zero length");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.empty) |-> sts.out_free)
		else $error("output register overwritten");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !(cmd.accept && sts.pend && sts.run_open))
		else $error("character accepted while a run flush is due");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the natural sort key encoder
// Streams file names one character per request and predicts every key result:
// lowered letters, run markers, saturated run lengths, buffered digits, capacity
// cut-off and the last/length tag. Runs several capacities and idle patterns.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned MAX_KEY      = 32;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned SETTLE       = 40;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam logic [7:0]  ASCII_0      = 8'h30;
	localparam logic [7:0]  ASCII_9      = 8'h39;
	localparam logic [7:0]  ASCII_UA     = 8'h41;
	localparam logic [7:0]  ASCII_UZ     = 8'h5A;
	localparam logic [7:0]  CASE_SHIFT   = 8'h20;
	localparam logic [7:0]  KEY_MARK     = 8'h30;
	localparam logic [7:0]  ZERO_RUN_LEN = 8'h01;
	localparam logic [7:0]  RUN_SAT      = 8'hFF;
	localparam logic [5:0]  CAP_AT_RESET = 6'd32;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} name_char_t;

	typedef struct packed {
		logic [7:0] kbyte;
		logic       bvalid;
		logic       klast;
		logic [5:0] klen;
	} key_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;     // [7:0] char_code
	logic        s_tlast = 1'b0;   // name_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // [7:0] key_byte, [13:8] key_length, [15:14] zero
	logic        m_tuser;          // byte_valid
	logic        m_tlast;          // key_last

	// stimulus and expectations
	name_char_t  chars_pending[$];
	name_char_t  name_buf[$];
	name_char_t  cur_char;
	key_res_t    key_q[$];
	key_res_t    step_q[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          rx_block = 1'b0;
	event        hold_start;
	int unsigned err_count = 0;
	int unsigned chars_sent = 0;
	int unsigned names_sent = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;

	// predictor state
	logic [7:0]  run_buf [MAX_KEY];
	logic [7:0]  run_len = '0;
	bit          run_open = 1'b0;
	int unsigned key_used = 0;
	logic [5:0]  cap_reg = CAP_AT_RESET;

	natural_sort_key_encoder #(.MAX_KEY(MAX_KEY)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, key_q.size());
			$display("tb: errors");
			$finish;
		end
	end

	// ---------------- key predictor ----------------

	function void emit_key_byte(input logic [7:0] b);
		key_res_t    r;
		int unsigned lim;
		lim = (cap_reg > MAX_KEY) ? MAX_KEY : cap_reg;
		if (key_used >= lim) return;
		r.kbyte  = b;
		r.bvalid = 1'b1;
		r.klast  = 1'b0;
		r.klen   = '0;
		step_q.push_back(r);
		key_used++;
	endfunction

	function void close_run();
		int unsigned i;
		int unsigned kept;
		if (!run_open) return;
		emit_key_byte(KEY_MARK);
		if (run_len == 0) begin
			// all-zero run keeps one zero digit
			emit_key_byte(ZERO_RUN_LEN);
			emit_key_byte(ASCII_0);
		end else begin
			emit_key_byte(run_len);
			kept = (run_len > MAX_KEY) ? MAX_KEY : run_len;
			for (i = 0; i < kept; i++) emit_key_byte(run_buf[i]);
		end
		run_open = 1'b0;
		run_len  = '0;
	endfunction

	function void encode_char(input name_char_t nc);
		key_res_t    r;
		int unsigned i;
		step_q.delete();
		if (nc.code >= ASCII_0 && nc.code <= ASCII_9) begin
			run_open = 1'b1;
			// drop leading zeros
			if (!(run_len == 0 && nc.code == ASCII_0)) begin
				if (run_len < MAX_KEY) run_buf[run_len] = nc.code;
				if (run_len < RUN_SAT) run_len++;
			end
		end else begin
			close_run();
			if (nc.code >= ASCII_UA && nc.code <= ASCII_UZ) begin
				emit_key_byte(nc.code + CASE_SHIFT);
			end else begin
				emit_key_byte(nc.code);
			end
		end
		if (nc.last) begin
			close_run();
			if (step_q.size() == 0) begin
				r = '0;
				step_q.push_back(r);
			end
			r = step_q.pop_back();
			r.klast = 1'b1;
			r.klen  = key_used[5:0];
			step_q.push_back(r);
			key_used = 0;
			run_len  = '0;
			run_open = 1'b0;
		end
		for (i = 0; i < step_q.size(); i++) key_q.push_back(step_q[i]);
	endfunction

	// ---------------- character driver ----------------

	always @(posedge clk) begin : drv
		bit took;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			took = s_tvalid && s_tready;
			if (took) begin
				encode_char(cur_char);
				chars_sent++;
				if (cur_char.last) names_sent++;
			end
			if (!s_tvalid || took) begin
				if (chars_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_char = chars_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= cur_char.code;
					s_tlast  <= cur_char.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------- key monitor ----------------

	always @(posedge clk) begin : mon
		key_res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (key_q.size() == 0) begin
					err_count++;
					$display("%0t: unexpected key result: byte %h valid %b last %b len %0d",
						$time, m_tdata[7:0], m_tuser, m_tlast, m_tdata[13:8]);
				end else begin
					want = key_q.pop_front();
					if (m_tdata[7:0] !== want.kbyte || m_tuser !== want.bvalid ||
						m_tlast !== want.klast || m_tdata[13:8] !== want.klen) begin
						err_count++;
						$display({"%0t: key mismatch: expected byte %h valid %b last %b len %0d,",
							" got byte %h valid %b last %b len %0d"}, $time,
							want.kbyte, want.bvalid, want.klast, want.klen,
							m_tdata[7:0], m_tuser, m_tlast, m_tdata[13:8]);
					end
				end
			end
			m_tready <= !rx_block && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// hold the receiver off on request
	initial begin : rx_hold
		forever begin
			@(hold_start);
			rx_block = 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			rx_block = 1'b0;
		end
	end

	// ---------------- stimulus ----------------

	task push_char(input logic [7:0] code);
		name_char_t nc;
		nc.code = code;
		nc.last = 1'b0;
		name_buf.push_back(nc);
	endtask

	task add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) push_char(s[i]);
	endtask

	// tag the final character and hand the name to the driver
	task close_name();
		name_char_t nc;
		nc = name_buf.pop_back();
		nc.last = 1'b1;
		name_buf.push_back(nc);
		while (name_buf.size() != 0) chars_pending.push_back(name_buf.pop_front());
	endtask

	task add_digit_run(input int unsigned len, input int unsigned zeros);
		int unsigned i;
		for (i = 0; i < zeros; i++) push_char(ASCII_0);
		for (i = 0; i < len; i++) push_char(8'($urandom_range(ASCII_0 + 1, ASCII_9)));
	endtask

	task add_random_names(input int unsigned n_chars);
		int unsigned target;
		int unsigned len;
		int unsigned j;
		int unsigned cls;
		string       punct;
		punct  = " -_./:@[`{~";
		target = chars_pending.size() + n_chars;
		while (chars_pending.size() < target) begin
			len = $urandom_range(1, 8);
			for (j = 0; j < len; j++) begin
				cls = $urandom_range(9);
				if (cls <= 1)
					push_char(8'($urandom_range(ASCII_UA, ASCII_UZ)));
				else if (cls <= 3)
					push_char(8'($urandom_range(ASCII_UA, ASCII_UZ)) + CASE_SHIFT);
				else if (cls <= 6)
					add_digit_run($urandom_range(0, 5),
						($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0);
				else if (cls == 7)
					push_char(punct[$urandom_range(punct.len() - 1)]);
				else if (cls == 8)
					push_char(8'($urandom_range(1, 255)));
				else
					push_char(8'($urandom_range(ASCII_0, ASCII_9)));
			end
			if (name_buf.size() == 0) push_char(ASCII_0);
			close_name();
		end
	endtask

	task write_capacity(input logic [5:0] cap);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_reg = cap;
	endtask

	// hold until the driver is empty and every expected result has come
	task wait_idle();
		while (chars_pending.size() != 0 || s_tvalid || key_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task run_phase(input logic [5:0] cap, input int unsigned send_pct,
		input int unsigned recv_pct, input bit long_runs);
		write_capacity(cap);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		add_random_names(8);
		if (long_runs) begin
			// run longer than the digit buffer, ended by a letter
			add_digit_run(40, 2);
			push_char("x");
			close_name();
			add_random_names(8);
			// block the output so the encoder backs up into its input
			-> hold_start;
			@(negedge clk);
			wait (!rx_block);
		end
		wait_idle();
	endtask

	initial begin : stim
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// letter and digit boundaries, byte extremes
		add_text("AZ@[`{");
		push_char(8'h01);
		push_char(8'hFF);
		add_text("/:");
		close_name();
		// all-zero run at name end
		add_text("000");
		close_name();
		// leading zeros, run closed by a non-digit, run open at name end
		add_text("x007-09a01");
		close_name();
		add_text("9");
		close_name();
		wait_idle();

		run_phase(6'd1,  0,  0,  1'b0);
		run_phase(6'd0,  73, 0,  1'b0);
		run_phase(6'd63, 0,  73, 1'b0);
		run_phase(6'd7,  8,  8,  1'b0);
		run_phase(6'd32, 0,  0,  1'b1);
		run_phase(6'd20, 73, 73, 1'b0);
		run_phase(6'd3,  8,  8,  1'b0);

		$display("summary: %0d names, %0d characters, %0d key results checked",
			names_sent, chars_sent, results_seen);
		$display("summary: capacities 32 1 0 63 7 32 20 3, a digit run past the buffer");
		if (err_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
